>>> src/bfem_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfem_pkg
// Shared constants, types and the reciprocal table for the 3x3 box filter.
// ----------------------------------------------------------------------------
package bfem_pkg;

  // Line buffer geometry
  localparam int MaxWidth    = 256;
  localparam int ColW        = $clog2(MaxWidth);
  localparam int PendW       = $clog2(MaxWidth + 1);

  // Field and register widths
  localparam int PixW        = 8;
  localparam int WidthW      = 9;
  localparam int HeightW     = 13;
  localparam int RowW        = 12;
  localparam int HeightLimit = 4096;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 13;

  // Mean arithmetic: nine 8-bit terms, divisor 1..9, fixed-point reciprocal
  localparam int SumW        = 12;
  localparam int CountW      = 4;
  localparam int RecipW      = 17;
  localparam int ScaleShift  = 16;
  localparam int ProdW       = SumW + RecipW;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } cfg_reg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic rd;
    logic update;
    logic sum;
    logic scale;
    logic load_out;
  } bfem_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic emit_due;
    logic out_free;
  } bfem_status_t;

  // ceil(2^16 / d) for each divisor that can occur; exact for sums below 4096
  function automatic logic [RecipW-1:0] recip(input logic [CountW-1:0] count);
    logic [RecipW-1:0] r;
    unique case (count)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/bfem_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfem_if
// Valid/ready channels of the box filter: pixel input, result output and
// configuration write.
// ----------------------------------------------------------------------------
interface bfem_in_if;
  import bfem_pkg::*;
  logic            valid;
  logic            ready;
  logic            mode;
  logic [PixW-1:0] pixel;
  modport source(output valid, output mode, output pixel, input ready);
  modport sink(input valid, input mode, input pixel, output ready);
endinterface

interface bfem_out_if;
  import bfem_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] smoothed;
  logic            frame_end;
  modport source(output valid, output smoothed, output frame_end, input ready);
  modport sink(input valid, input smoothed, input frame_end, output ready);
endinterface

interface bfem_cfg_if;
  import bfem_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> src/bfem_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfem_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfem_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> src/bfem_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfem_ctrl
// Sequencer: one word at a time through read and update, then through sum, scale
// and emit for a word that yields a result.
module bfem_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire bfem_pkg::bfem_status_t  status,
  output bfem_pkg::bfem_cmd_t          cmd
);
  import bfem_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_SUM,
    S_SCALE,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_READ;
      S_READ:   state_next = S_UPDATE;
      S_UPDATE: state_next = status.emit_due ? S_SUM : S_IDLE;
      S_SUM:    state_next = S_SCALE;
      S_SCALE:  state_next = S_EMIT;
      S_EMIT:   if (status.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready <= 1'b1;
    end else begin
      state <= state_next;
      ready <= (state_next == S_IDLE);
    end
  end

  assign in_ready = ready;

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.capture  = ready && in_valid;
    cmd.rd       = (state == S_READ);
    cmd.update   = (state == S_UPDATE);
    cmd.sum      = (state == S_SUM);
    cmd.scale    = (state == S_SCALE);
    cmd.load_out = (state == S_EMIT) && status.out_free;
  end

endmodule
`default_nettype wire

>>> src/bfem_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfem_datapath
// Line buffers, 3x3 window, raster counters, masked sum, reciprocal scale
// and the output register.
// ----------------------------------------------------------------------------
module bfem_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire bfem_pkg::bfem_cmd_t              cmd,
  output bfem_pkg::bfem_status_t                status,
  input  wire logic                             in_mode,
  input  wire logic [bfem_pkg::PixW-1:0]        in_pixel,
  input  wire logic                             cfg_valid,
  input  wire logic [bfem_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [bfem_pkg::CfgDataW-1:0]    cfg_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [bfem_pkg::PixW-1:0]        out_smoothed,
  output logic                                  out_frame_end
);
  import bfem_pkg::*;

  // configuration
  logic [WidthW-1:0]  frame_width;
  logic [HeightW-1:0] frame_height;
  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;

  // captured word
  logic               item_mode;
  logic [PixW-1:0]    item_pixel;

  // raster counters
  logic [ColW-1:0]    in_col;
  logic [RowW-1:0]    in_row;
  logic [ColW-1:0]    out_col;
  logic [RowW-1:0]    out_row;
  logic [PendW-1:0]   pending;

  // line buffers
  logic [ColW-1:0]    rd_addr;
  logic [PixW-1:0]    above_rd;
  logic [PixW-1:0]    two_above_rd;
  logic               buf_wr;

  // window and arithmetic
  logic [PixW-1:0]    win [3][3];
  logic [PixW-1:0]    bot;
  logic               shift_en;
  logic [SumW-1:0]    sum_c;
  logic [CountW-1:0]  cnt_c;
  logic [SumW-1:0]    sum_q;
  logic [CountW-1:0]  cnt_q;
  logic               end_c;
  logic               end_q;
  logic               end_s;
  logic [ProdW-1:0]   prod_q;
  logic [2:0]         rv;
  logic [2:0]         cv;

  // counter helpers
  logic [WidthW-1:0]  in_col_inc;
  logic [WidthW-1:0]  out_col_inc;
  logic [HeightW-1:0] in_row_inc;
  logic [HeightW-1:0] out_row_inc;
  logic [PendW-1:0]   pending_inc;
  logic [ColW-1:0]    drain_col;

  // clamp register values to the usable range
  always_comb begin
    if (frame_width == '0) begin
      w_eff = WidthW'(1);
    end else if (frame_width > WidthW'(MaxWidth)) begin
      w_eff = WidthW'(MaxWidth);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = HeightW'(1);
    end else if (frame_height > HeightW'(HeightLimit)) begin
      h_eff = HeightW'(HeightLimit);
    end else begin
      h_eff = frame_height;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WidthW'(256);
      frame_height <= HeightW'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        RegFrameWidth:  frame_width  <= cfg_data[WidthW-1:0];
        RegFrameHeight: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode  <= in_mode;
      item_pixel <= in_pixel;
    end
  end

  assign in_col_inc  = WidthW'(in_col) + 1'b1;
  assign out_col_inc = WidthW'(out_col) + 1'b1;
  assign in_row_inc  = HeightW'(in_row) + 1'b1;
  assign out_row_inc = HeightW'(out_row) + 1'b1;
  assign pending_inc = pending + 1'b1;

  // a drain reads the column after the pending output, wrapping at row end
  assign drain_col = (out_col_inc >= w_eff) ? '0 : out_col_inc[ColW-1:0];
  assign rd_addr   = item_mode ? drain_col : in_col;

  // a pixel yields a result once more than a row is pending
  assign status.emit_due = item_mode ? (pending != '0) : (pending_inc > PendW'(w_eff));
  assign status.out_free = !out_valid || out_ready;

  assign buf_wr = cmd.update && !item_mode;

  bfem_ram #(
    .Width (PixW),
    .Depth (MaxWidth)
  ) u_row_above (
    .clk     (clk),
    .wr_en   (buf_wr),
    .wr_addr (in_col),
    .wr_data (item_pixel),
    .rd_en   (cmd.rd),
    .rd_addr (rd_addr),
    .rd_data (above_rd)
  );

  bfem_ram #(
    .Width (PixW),
    .Depth (MaxWidth)
  ) u_row_two_above (
    .clk     (clk),
    .wr_en   (buf_wr),
    .wr_addr (in_col),
    .wr_data (above_rd),
    .rd_en   (cmd.rd),
    .rd_addr (rd_addr),
    .rd_data (two_above_rd)
  );

  // window shift: on every pixel, and on a drain that yields a result
  assign shift_en = cmd.update && (!item_mode || status.emit_due);
  assign bot      = item_mode ? '0 : item_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (shift_en) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= two_above_rd;
      win[1][2] <= above_rd;
      win[2][2] <= bot;
    end
  end

  // neighbour masks from the output position
  assign rv[0] = (out_row != '0);
  assign rv[1] = 1'b1;
  assign rv[2] = (out_row_inc < h_eff);
  assign cv[0] = (out_col != '0);
  assign cv[1] = 1'b1;
  assign cv[2] = (out_col_inc < w_eff);

  always_comb begin
    sum_c = '0;
    cnt_c = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (rv[r] && cv[c]) begin
          sum_c = sum_c + SumW'(win[r][c]);
          cnt_c = cnt_c + 1'b1;
        end
      end
    end
  end

  assign end_c = (HeightW'(out_row) == h_eff - 1'b1) && (WidthW'(out_col) == w_eff - 1'b1);

  // sum stage, then reciprocal multiply
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sum_q <= sum_c;
      cnt_q <= cnt_c;
      end_q <= end_c;
    end
    if (cmd.scale) begin
      prod_q <= ProdW'(sum_q) * ProdW'(recip(cnt_q));
      end_s  <= end_q;
    end
  end

  // counters and pending count
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      pending <= '0;
    end else begin
      if (buf_wr) begin
        pending <= pending_inc;
        if (in_col_inc >= w_eff) begin
          in_col <= '0;
          in_row <= (in_row_inc >= h_eff) ? '0 : in_row_inc[RowW-1:0];
        end else begin
          in_col <= in_col_inc[ColW-1:0];
        end
      end
      if (cmd.load_out) begin
        pending <= pending - 1'b1;
        if (out_col_inc >= w_eff) begin
          out_col <= '0;
          out_row <= (out_row_inc >= h_eff) ? '0 : out_row_inc[RowW-1:0];
        end else begin
          out_col <= out_col_inc[ColW-1:0];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_smoothed  <= prod_q[ScaleShift +: PixW];
      out_frame_end <= end_s;
    end
  end

endmodule
`default_nettype wire

>>> src/box_filter_3x3_edge_mean.sv
`default_nettype none
// A word that yields a result goes through the read, update, sum, scale and
// emit states before it shows; emit waits while the output register is full.
// A new word is taken only when the sequencer is back in idle.
// Reset (rst, synchronous): counters, window and pending count cleared,
// width 256, height 1. Line buffer contents stay undefined until written.
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_mean
// 3x3 mean filter over a raster pixel stream with edge-aware divisors and
// drain words to flush the last row.
// ----------------------------------------------------------------------------
module box_filter_3x3_edge_mean (
  input  wire logic clk,
  input  wire logic rst,
  bfem_in_if.sink   pixels,
  bfem_out_if.source results,
  bfem_cfg_if.sink  cfg
);
  import bfem_pkg::*;

  bfem_cmd_t    cmd;
  bfem_status_t status;

  // configuration is always taken
  assign cfg.ready = 1'b1;

  bfem_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixels.valid),
    .in_ready (pixels.ready),
    .status   (status),
    .cmd      (cmd)
  );

  bfem_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_mode       (pixels.mode),
    .in_pixel      (pixels.pixel),
    .cfg_valid     (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .out_smoothed  (results.smoothed),
    .out_frame_end (results.frame_end)
  );

  // one word in flight at a time
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && pixels.ready) |=> !pixels.ready)
    else $error("word accepted while another is in flight");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!results.valid || results.ready))
    else $error("result register overwritten");

  // a result is loaded only at the end of the sequence, never while ready
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !pixels.ready)
    else $error("result loaded while idle");

endmodule
`default_nettype wire
